// ----- sv/salsa20_pkg.sv -----
package salsa20_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Words   = 16;
  localparam int unsigned MsgW    = 64;
  localparam int unsigned CountW  = 4;
  localparam int unsigned OffsetW = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CtrW    = 64;

  localparam logic [CountW-1:0] FullCount = CountW'(8);
  localparam logic [OffsetW-1:0] LastOffset = '1;

  localparam logic [WordW-1:0] Sigma0 = 32'h6170_7865;
  localparam logic [WordW-1:0] Sigma1 = 32'h3320_646e;
  localparam logic [WordW-1:0] Sigma2 = 32'h7962_2d32;
  localparam logic [WordW-1:0] Sigma3 = 32'h6b20_6574;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_0_1 = 3'd0,
    CFG_KEY_2_3 = 3'd1,
    CFG_KEY_4_5 = 3'd2,
    CFG_KEY_6_7 = 3'd3,
    CFG_NONCE   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CORE_IDLE,
    CORE_RUN
  } core_state_e;

  typedef logic [Words-1:0][WordW-1:0] state_t;
  typedef logic [3:0][CfgW-1:0] key_t;

  typedef struct packed {
    logic [MsgW-1:0]   msg_bytes;
    logic [CountW-1:0] byte_count;
    logic              msg_last;
  } in_item_t;

  typedef struct packed {
    logic [MsgW-1:0]   out_bytes;
    logic [CountW-1:0] out_count;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic [MsgW-1:0]    msg_bytes;
    logic [CountW-1:0]  byte_count;
    logic               msg_last;
    logic [OffsetW-1:0] word_offset;
  } item_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int s);
    return (v << s) | (v >> (WordW - s));
  endfunction

  function automatic logic [4*WordW-1:0] quarter(input logic [WordW-1:0] a,
                                                 input logic [WordW-1:0] b,
                                                 input logic [WordW-1:0] c,
                                                 input logic [WordW-1:0] d);
    logic [WordW-1:0] b1, c1, d1, a1;
    b1 = b ^ rotl(a + d, 7);
    c1 = c ^ rotl(b1 + a, 9);
    d1 = d ^ rotl(c1 + b1, 13);
    a1 = a ^ rotl(d1 + c1, 18);
    return {a1, b1, c1, d1};
  endfunction

  function automatic state_t column_round(input state_t x);
    state_t y;
    {y[0], y[4], y[8], y[12]}   = quarter(x[0], x[4], x[8], x[12]);
    {y[5], y[9], y[13], y[1]}   = quarter(x[5], x[9], x[13], x[1]);
    {y[10], y[14], y[2], y[6]}  = quarter(x[10], x[14], x[2], x[6]);
    {y[15], y[3], y[7], y[11]}  = quarter(x[15], x[3], x[7], x[11]);
    return y;
  endfunction

  function automatic state_t row_round(input state_t x);
    state_t y;
    {y[0], y[1], y[2], y[3]}     = quarter(x[0], x[1], x[2], x[3]);
    {y[5], y[6], y[7], y[4]}     = quarter(x[5], x[6], x[7], x[4]);
    {y[10], y[11], y[8], y[9]}   = quarter(x[10], x[11], x[8], x[9]);
    {y[15], y[12], y[13], y[14]} = quarter(x[15], x[12], x[13], x[14]);
    return y;
  endfunction

  function automatic state_t init_state(input key_t key, input logic [CfgW-1:0] nonce,
                                        input logic [CtrW-1:0] ctr);
    state_t s;
    s[0]  = Sigma0;
    s[1]  = key[0][31:0];
    s[2]  = key[0][63:32];
    s[3]  = key[1][31:0];
    s[4]  = key[1][63:32];
    s[5]  = Sigma1;
    s[6]  = nonce[31:0];
    s[7]  = nonce[63:32];
    s[8]  = ctr[31:0];
    s[9]  = ctr[63:32];
    s[10] = Sigma2;
    s[11] = key[2][31:0];
    s[12] = key[2][63:32];
    s[13] = key[3][31:0];
    s[14] = key[3][63:32];
    s[15] = Sigma3;
    return s;
  endfunction

endpackage

// ----- sv/salsa20_stream_cipher_top.sv -----
// Salsa20 stream cipher: message data comes in eight bytes per item on the input channel
// and leaves XORed with the keystream on the output channel, one result per item, in order.
// Key and nonce are loaded via the write port; the user must do it while idle (unenforced).
// The front stage tracks the block counter and word position and queues the items; it
// posts a keystream request for every item that opens a 64-byte block.
// The core runs one double-half round step per cycle; two block buffers let the next block
// be computed while the current one is used.
// An item whose keystream block is ready passes through the item queue and the output
// register; an item that opens a new block also waits for the core to compute its block.
// Throughput is one item per cycle inside a block while the receiver does not stall;
// sustained over long messages it is set by the core.
// Reset clears the key, the nonce, the counter and the queues, and marks both block buffers empty.
// While the receiver stalls, the output register holds its result, the queues fill and
// in_stall_o then rises; no item is lost.
module salsa20_stream_cipher_top #(
  parameter int unsigned ROUND_COUNT = 20,
  parameter int unsigned ITEM_DEPTH  = 16,
  parameter int unsigned REQ_DEPTH   = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  salsa20_pkg::in_item_t               in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output salsa20_pkg::out_item_t              out_data_o,
  input  logic                                cfg_we_i,
  input  logic [salsa20_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [salsa20_pkg::CfgW-1:0]        cfg_data_i
);

  localparam int unsigned ItemW = $bits(salsa20_pkg::item_t);

  salsa20_pkg::key_t              key_q;
  logic [salsa20_pkg::CfgW-1:0]   nonce_q;

  logic                           item_push, item_full, item_pop, item_empty;
  salsa20_pkg::item_t             item_in, item_out;
  logic                           req_push, req_full, req_pop, req_empty;
  logic [salsa20_pkg::CtrW-1:0]   req_ctr_in, req_ctr_out;
  logic                           buf_free, blk_valid;
  salsa20_pkg::state_t            blk_words;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      nonce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        salsa20_pkg::CFG_KEY_0_1: key_q[0] <= cfg_data_i;
        salsa20_pkg::CFG_KEY_2_3: key_q[1] <= cfg_data_i;
        salsa20_pkg::CFG_KEY_4_5: key_q[2] <= cfg_data_i;
        salsa20_pkg::CFG_KEY_6_7: key_q[3] <= cfg_data_i;
        salsa20_pkg::CFG_NONCE:   nonce_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  salsa20_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .item_push_o (item_push),
    .item_data_o (item_in),
    .item_full_i (item_full),
    .req_push_o  (req_push),
    .req_ctr_o   (req_ctr_in),
    .req_full_i  (req_full)
  );

  salsa20_fifo #(
    .WIDTH (ItemW),
    .DEPTH (ITEM_DEPTH)
  ) u_item_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (item_push),
    .push_data_i (item_in),
    .full_o      (item_full),
    .pop_i       (item_pop),
    .pop_data_o  (item_out),
    .empty_o     (item_empty)
  );

  salsa20_fifo #(
    .WIDTH (salsa20_pkg::CtrW),
    .DEPTH (REQ_DEPTH)
  ) u_req_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (req_push),
    .push_data_i (req_ctr_in),
    .full_o      (req_full),
    .pop_i       (req_pop),
    .pop_data_o  (req_ctr_out),
    .empty_o     (req_empty)
  );

  salsa20_core #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .nonce_i     (nonce_q),
    .req_valid_i (~req_empty),
    .req_ctr_i   (req_ctr_out),
    .req_pop_o   (req_pop),
    .buf_free_i  (buf_free),
    .blk_valid_o (blk_valid),
    .blk_words_o (blk_words)
  );

  salsa20_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (~item_empty),
    .item_data_i  (item_out),
    .item_pop_o   (item_pop),
    .blk_valid_i  (blk_valid),
    .blk_words_i  (blk_words),
    .buf_free_o   (buf_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ----- sv/salsa20_fifo.sv -----
module salsa20_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/salsa20_front.sv -----
module salsa20_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  salsa20_pkg::in_item_t                   in_data_i,
  output logic                                    item_push_o,
  output salsa20_pkg::item_t                      item_data_o,
  input  logic                                    item_full_i,
  output logic                                    req_push_o,
  output logic [salsa20_pkg::CtrW-1:0]            req_ctr_o,
  input  logic                                    req_full_i
);

  logic [salsa20_pkg::CtrW-1:0]    ctr_q, ctr_d;
  logic [salsa20_pkg::OffsetW-1:0] offset_q, offset_d;
  logic                            new_block, accept;

  assign new_block  = (offset_q == '0);
  assign in_stall_o = item_full_i | (new_block & req_full_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign item_push_o = accept;
  assign req_push_o  = accept & new_block;
  assign req_ctr_o   = ctr_q;

  always_comb begin
    item_data_o.msg_bytes   = in_data_i.msg_bytes;
    item_data_o.byte_count  = (in_data_i.byte_count > salsa20_pkg::FullCount)
                            ? salsa20_pkg::FullCount : in_data_i.byte_count;
    item_data_o.msg_last    = in_data_i.msg_last;
    item_data_o.word_offset = offset_q;
  end

  always_comb begin
    ctr_d    = ctr_q;
    offset_d = offset_q;
    if (accept) begin
      offset_d = offset_q + salsa20_pkg::OffsetW'(1);
      if (offset_q == salsa20_pkg::LastOffset) begin
        ctr_d = ctr_q + salsa20_pkg::CtrW'(1);
      end
      if (in_data_i.msg_last) begin
        ctr_d    = '0;
        offset_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q    <= '0;
      offset_q <= '0;
    end else begin
      ctr_q    <= ctr_d;
      offset_q <= offset_d;
    end
  end

endmodule

// ----- sv/salsa20_core.sv -----
module salsa20_core #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  salsa20_pkg::key_t               key_i,
  input  logic [salsa20_pkg::CfgW-1:0]    nonce_i,
  input  logic                            req_valid_i,
  input  logic [salsa20_pkg::CtrW-1:0]    req_ctr_i,
  output logic                            req_pop_o,
  input  logic                            buf_free_i,
  output logic                            blk_valid_o,
  output salsa20_pkg::state_t             blk_words_o
);

  localparam int unsigned RW = $clog2(ROUND_COUNT);

  salsa20_pkg::core_state_e state_q, state_d;
  salsa20_pkg::state_t      work_q, work_d, init_q, init_d, round_out;
  logic [RW-1:0]            round_q, round_d;
  logic                     final_round;

  assign round_out   = round_q[0] ? salsa20_pkg::row_round(work_q)
                                  : salsa20_pkg::column_round(work_q);
  assign final_round = (round_q == RW'(ROUND_COUNT - 1));

  always_comb begin
    for (int k = 0; k < salsa20_pkg::Words; k++) begin
      blk_words_o[k] = round_out[k] + init_q[k];
    end
  end

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    init_d      = init_q;
    round_d     = round_q;
    req_pop_o   = 1'b0;
    blk_valid_o = 1'b0;
    unique case (state_q)
      salsa20_pkg::CORE_IDLE: begin
        if (req_valid_i && buf_free_i) begin
          req_pop_o = 1'b1;
          init_d    = salsa20_pkg::init_state(key_i, nonce_i, req_ctr_i);
          work_d    = init_d;
          round_d   = '0;
          state_d   = salsa20_pkg::CORE_RUN;
        end
      end
      salsa20_pkg::CORE_RUN: begin
        work_d  = round_out;
        round_d = round_q + RW'(1);
        if (final_round) begin
          blk_valid_o = 1'b1;
          state_d     = salsa20_pkg::CORE_IDLE;
        end
      end
      default: state_d = salsa20_pkg::CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= salsa20_pkg::CORE_IDLE;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    init_q <= init_d;
  end

endmodule

// ----- sv/salsa20_back.sv -----
module salsa20_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  input  salsa20_pkg::item_t     item_data_i,
  output logic                   item_pop_o,
  input  logic                   blk_valid_i,
  input  salsa20_pkg::state_t    blk_words_i,
  output logic                   buf_free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output salsa20_pkg::out_item_t out_data_o
);

  salsa20_pkg::state_t       ks_q [2];
  logic [1:0]                full_q, full_d;
  logic                      wr_sel_q, wr_sel_d, rd_sel_q, rd_sel_d;
  logic                      out_valid_q, out_valid_d, release_blk;
  salsa20_pkg::out_item_t    out_q, out_d;
  logic [salsa20_pkg::MsgW-1:0] ks_pair, mask;
  logic [3:0]                lo_idx, hi_idx;

  assign buf_free_o  = ~full_q[wr_sel_q];
  assign item_pop_o  = item_valid_i & full_q[rd_sel_q] & (~out_valid_q | ~out_stall_i);
  assign release_blk = item_pop_o & (item_data_i.msg_last |
                       (item_data_i.word_offset == salsa20_pkg::LastOffset));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lo_idx  = {item_data_i.word_offset, 1'b0};
  assign hi_idx  = {item_data_i.word_offset, 1'b1};
  assign ks_pair = {ks_q[rd_sel_q][hi_idx], ks_q[rd_sel_q][lo_idx]};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[8*i +: 8] = {8{(item_data_i.byte_count > salsa20_pkg::CountW'(i))}};
    end
    out_d.out_bytes = (item_data_i.msg_bytes ^ ks_pair) & mask;
    out_d.out_count = item_data_i.byte_count;
    out_d.out_last  = item_data_i.msg_last;
  end

  always_comb begin
    full_d      = full_q;
    wr_sel_d    = wr_sel_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = item_pop_o | (out_valid_q & out_stall_i);
    if (blk_valid_i) begin
      full_d[wr_sel_q] = 1'b1;
      wr_sel_d         = ~wr_sel_q;
    end
    if (release_blk) begin
      full_d[rd_sel_q] = 1'b0;
      rd_sel_d         = ~rd_sel_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= '0;
      wr_sel_q    <= 1'b0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      full_q      <= full_d;
      wr_sel_q    <= wr_sel_d;
      rd_sel_q    <= rd_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_valid_i) begin
      ks_q[wr_sel_q] <= blk_words_i;
    end
    if (item_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule
